>>> rtl/dlm_pkg.sv
// ---------------------------------------------------------------------------
// dlm_pkg
// Shared types, sizes and codes for the device liveness monitor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlm_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int TIME_W = 32;
  localparam int THR_W  = 24;
  localparam int SID_W  = 16;
  localparam int ROOM_W = 8;
  localparam int TEMP_W = 16;
  localparam int HUM_W  = 14;
  localparam int RDG_W  = 16;
  localparam int OCNT_W = 6;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE = 2'd1;
  localparam logic [THR_W-1:0] WARNING_RESET = 24'd300;
  localparam logic [THR_W-1:0] OFFLINE_RESET = 24'd600;

  // Opcodes
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;

  // Device status
  localparam logic [1:0] ST_ONLINE  = 2'd0;
  localparam logic [1:0] ST_WARNING = 2'd1;
  localparam logic [1:0] ST_OFFLINE = 2'd2;

  // Global status
  localparam logic [1:0] SUM_HEALTHY  = 2'd0;
  localparam logic [1:0] SUM_WARNING  = 2'd1;
  localparam logic [1:0] SUM_CRITICAL = 2'd2;

  // One table row
  typedef struct packed {
    logic [SID_W-1:0]         sensor;
    logic [ROOM_W-1:0]        room;
    logic [TIME_W-1:0]        seen_at;
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic [RDG_W-1:0]         readings;
  } entry_t;

endpackage

>>> rtl/device_liveness_monitor_top.sv
// ---------------------------------------------------------------------------
// device_liveness_monitor_top
// Sensor table with report registration, liveness classification and listing.
// ---------------------------------------------------------------------------
// Usage: pulse start with an item while busy is low. A report (opcode 0)
// looks up device_id, updates the known sensor or registers a new one (drops
// it if the table is full), answering with one summary item. A query (op 1)
// lists one record item per registered device, then a summary with last high.
// Thresholds use the cfg_valid/cfg_ready channel (always ready), index 0
// warning, index 1 offline. The user must write them only while the block
// is idle; the block does not enforce it. Timing: one table row is read per
// cycle through a registered memory port, and one shared classifier checks
// each row as it arrives. Busy covers the row scan, a drain and a finish step
// (an empty table goes straight to finish); the summary strobes the cycle
// after busy falls, records stream one per cycle. Results are shown for one
// cycle on result_valid; the receiver cannot stall them.
// Reset empties the table (device count 0) and loads thresholds 300 and 600;
// row contents need no clearing since only rows below the count are read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module device_liveness_monitor_top
  import dlm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode,
  input  logic [TIME_W-1:0]        now_seconds,
  input  logic [SID_W-1:0]         device_id,
  input  logic [ROOM_W-1:0]        room_id,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic [HUM_W-1:0]         humidity,
  // configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [THR_W-1:0]         cfg_data,
  // result channel
  output logic                     result_valid,
  output logic                     last,
  output logic [1:0]               kind,
  output logic [SID_W-1:0]         out_device_id,
  output logic [ROOM_W-1:0]        out_room_id,
  output logic [1:0]               status,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic [HUM_W-1:0]         out_humidity,
  output logic [RDG_W-1:0]         reading_count,
  output logic [OCNT_W-1:0]        total_count,
  output logic [OCNT_W-1:0]        online_count,
  output logic [OCNT_W-1:0]        warning_count,
  output logic [OCNT_W-1:0]        offline_count
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
  localparam logic [RDG_W-1:0] RDG_MAX    = '1;

  logic [1:0]        state;
  logic [CNT_W-1:0]  addr;
  logic [CNT_W-1:0]  device_count;
  logic [THR_W-1:0]  warning_after_seconds;
  logic [THR_W-1:0]  offline_after_seconds;

  // latched item
  logic                     req_op;
  logic [TIME_W-1:0]        req_now;
  logic [SID_W-1:0]         req_sid;
  logic [ROOM_W-1:0]        req_room;
  logic signed [TEMP_W-1:0] req_temp;
  logic [HUM_W-1:0]         req_hum;

  // table and read port
  entry_t            table_mem [TABLE_DEPTH];
  entry_t            rd_data;
  logic              rd_valid;

  // scan results
  logic              found;
  logic [IDX_W-1:0]  match_idx;
  logic [1:0]        match_status;
  logic [ROOM_W-1:0] match_room;
  logic [RDG_W-1:0]  match_readings;
  logic [CNT_W-1:0]  cnt_on;
  logic [CNT_W-1:0]  cnt_warn;
  logic [CNT_W-1:0]  cnt_off;

  // classifier and finish logic
  logic [TIME_W-1:0] elapsed;
  logic [1:0]        rd_status;
  logic [CNT_W-1:0]  fin_on;
  logic [CNT_W-1:0]  fin_warn;
  logic [CNT_W-1:0]  fin_off;
  logic [CNT_W-1:0]  fin_total;
  logic [1:0]        fin_kind;
  logic [1:0]        fin_global;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  entry_t            wr_entry;
  logic              accept;
  logic              scan_end;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign scan_end  = (CNT_W'(addr + 1'b1) == device_count);

  // Classify the row on the read port against both thresholds
  always_comb begin
    elapsed = (req_now >= rd_data.seen_at) ? (req_now - rd_data.seen_at) : '0;
    if (elapsed > TIME_W'(offline_after_seconds)) begin
      rd_status = ST_OFFLINE;
    end else if (elapsed > TIME_W'(warning_after_seconds)) begin
      rd_status = ST_WARNING;
    end else begin
      rd_status = ST_ONLINE;
    end
  end

  // Fold the report into the counts and build the row to write back
  always_comb begin
    fin_on    = cnt_on;
    fin_warn  = cnt_warn;
    fin_off   = cnt_off;
    fin_total = device_count;
    fin_kind  = KIND_SUMMARY;
    wr_en     = 1'b0;
    wr_idx    = match_idx;
    wr_entry.sensor      = req_sid;
    wr_entry.room        = match_room;
    wr_entry.seen_at     = req_now;
    wr_entry.temperature = req_temp;
    wr_entry.humidity    = req_hum;
    wr_entry.readings    = (match_readings == RDG_MAX) ? RDG_MAX
                                                       : RDG_W'(match_readings + 1'b1);
    if (req_op == OP_REPORT) begin
      if (found) begin
        // the updated row moves to online
        case (match_status)
          ST_WARNING: fin_warn = CNT_W'(cnt_warn - 1'b1);
          ST_OFFLINE: fin_off  = CNT_W'(cnt_off - 1'b1);
          default:    fin_on   = CNT_W'(cnt_on - 1'b1);
        endcase
        fin_on = CNT_W'(fin_on + 1'b1);
        wr_en  = 1'b1;
      end else if (device_count == FULL_COUNT) begin
        // drop the unknown sensor, table untouched
        fin_kind = KIND_DROPPED;
      end else begin
        fin_on            = CNT_W'(cnt_on + 1'b1);
        fin_total         = CNT_W'(device_count + 1'b1);
        wr_en             = 1'b1;
        wr_idx            = device_count[IDX_W-1:0];
        wr_entry.room     = req_room;
        wr_entry.readings = RDG_W'(1);
      end
    end
    if (fin_off != '0) begin
      fin_global = SUM_CRITICAL;
    end else if (fin_warn != '0) begin
      fin_global = SUM_WARNING;
    end else begin
      fin_global = SUM_HEALTHY;
    end
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (state == S_FINISH && wr_en) begin
      table_mem[wr_idx] <= wr_entry;
    end
    rd_data <= table_mem[addr[IDX_W-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      warning_after_seconds <= WARNING_RESET;
      offline_after_seconds <= OFFLINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WARNING: warning_after_seconds <= cfg_data;
        CFG_OFFLINE: offline_after_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      addr         <= '0;
      device_count <= '0;
      rd_valid     <= 1'b0;
    end else begin
      rd_valid <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          addr <= '0;
          if (accept) begin
            state <= (device_count == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          addr <= CNT_W'(addr + 1'b1);
          if (scan_end) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          device_count <= fin_total;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the item and accumulate the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (rd_valid && !found && rd_data.sensor == req_sid) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= opcode;
      req_now  <= now_seconds;
      req_sid  <= device_id;
      req_room <= room_id;
      req_temp <= temperature;
      req_hum  <= humidity;
      cnt_on   <= '0;
      cnt_warn <= '0;
      cnt_off  <= '0;
    end else if (rd_valid) begin
      case (rd_status)
        ST_WARNING: cnt_warn <= CNT_W'(cnt_warn + 1'b1);
        ST_OFFLINE: cnt_off  <= CNT_W'(cnt_off + 1'b1);
        default:    cnt_on   <= CNT_W'(cnt_on + 1'b1);
      endcase
      if (!found && rd_data.sensor == req_sid) begin
        match_idx      <= CNT_W'(addr - 1'b1) < CNT_W'(TABLE_DEPTH) ?
                          IDX_W'(CNT_W'(addr - 1'b1)) : '0;
        match_status   <= rd_status;
        match_room     <= rd_data.room;
        match_readings <= rd_data.readings;
      end
    end
  end

  // Result register: records during a query scan, summary at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (rd_valid && req_op == OP_QUERY) || (state == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      last            <= 1'b1;
      kind            <= fin_kind;
      out_device_id   <= '0;
      out_room_id     <= '0;
      status          <= fin_global;
      out_temperature <= '0;
      out_humidity    <= '0;
      reading_count   <= '0;
      total_count     <= OCNT_W'(fin_total);
      online_count    <= OCNT_W'(fin_on);
      warning_count   <= OCNT_W'(fin_warn);
      offline_count   <= OCNT_W'(fin_off);
    end else begin
      last            <= 1'b0;
      kind            <= KIND_RECORD;
      out_device_id   <= rd_data.sensor;
      out_room_id     <= rd_data.room;
      status          <= rd_status;
      out_temperature <= rd_data.temperature;
      out_humidity    <= rd_data.humidity;
      reading_count   <= rd_data.readings;
      total_count     <= '0;
      online_count    <= '0;
      warning_count   <= '0;
      offline_count   <= '0;
    end
  end

endmodule

>>> rtl/dlm_checker.sv
// ---------------------------------------------------------------------------
// dlm_checker
// Port-level checks on the liveness monitor's command and result channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlm_checker
  import dlm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic       last,
  input logic [1:0] kind
);

  // An accepted item holds the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  // Device records never close an item
  a_record_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_RECORD |-> !last)
    else $error("device record marked last");

  // Summaries always close an item
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_SUMMARY || kind == KIND_DROPPED) |-> last)
    else $error("summary not marked last");

  // Records stream only while the item is in work
  a_record_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_RECORD |-> busy)
    else $error("device record outside an item");

  // Nothing follows a closing result straight away
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result straight after a closing result");

endmodule

bind device_liveness_monitor_top dlm_checker u_dlm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .last         (last),
  .kind         (kind)
);
